// ===== hdl/cidat_pkg.sv =====
// cidat_pkg: shared types and constants for the card id access table
// depends on nothing; used by cidat_cell, card_id_access_table_core and the test bench
`timescale 1ns / 1ps

package cidat_pkg;

  // default table depth
  localparam int CAPACITY_DEF = 32;

  // field widths
  localparam int UID_W     = 32;
  localparam int COUNT_W   = 6;
  // widest slot index and fill count over the supported depth range (up to 256)
  localparam int SLOT_MAX_W = 8;
  localparam int CNT_MAX_W  = 9;

  // result codes
  typedef enum logic [3:0] {
    OC_MASTER_SET = 4'd0,
    OC_ENTER_PROG = 4'd1,
    OC_EXIT_PROG  = 4'd2,
    OC_ADDED      = 4'd3,
    OC_REMOVED    = 4'd4,
    OC_GRANTED    = 4'd5,
    OC_DENIED     = 4'd6,
    OC_FULL       = 4'd7,
    OC_WIPED      = 4'd8
  } outcome_t;

  // input beat
  typedef struct packed {
    logic             action;
    logic [UID_W-1:0] card_uid;
  } in_t;

  // result beat
  typedef struct packed {
    outcome_t           outcome;
    logic [COUNT_W-1:0] record_count;
    logic               in_program_mode;
  } out_t;

  // control broadcast to every table cell
  typedef struct packed {
    logic                  rotate;
    logic                  remove;
    logic                  append;
    logic [SLOT_MAX_W-1:0] slot;
    logic [CNT_MAX_W-1:0]  count;
    logic [UID_W-1:0]      uid;
  } cell_cmd_t;

endpackage

// ===== hdl/card_id_access_table_core.sv =====
// card_id_access_table_core: master card, program mode and a ring of id cells
// depends on cidat_pkg and cidat_cell
`timescale 1ns / 1ps
//
//  channel   direction  ports                 handshake
//  item      in         item (in_t)           start & !busy
//  result    out        result (out_t)        done, one cycle, no stall
//
// every item runs from accept to the next accept through S_SEARCH, where
// one full rotation of the cell ring searches the table, and S_FINISH,
// which applies the decision; the result shows as start may be raised
// again. removal shifts the upper cells down at once in S_FINISH.
// reset clears master, mode and count; the cell contents need no clearing.
// the receiver cannot stall: done is high for exactly one cycle per item.

module card_id_access_table_core #(
  parameter int CAPACITY = cidat_pkg::CAPACITY_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  cidat_pkg::in_t  item,
  output logic            done,
  output cidat_pkg::out_t result
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SEARCH = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t                       state;
  logic                         action;
  logic [cidat_pkg::UID_W-1:0]  uid;
  logic [cidat_pkg::UID_W-1:0]  master_id;
  logic                         master_valid;
  logic                         program_mode;
  logic [CNT_W-1:0]             count;
  logic [IDX_W-1:0]             step;
  logic                         found;
  logic [IDX_W-1:0]             slot;

  logic                         master_id_load;
  logic                         master_valid_next;
  logic                         program_mode_next;
  logic [CNT_W-1:0]             count_next;
  cidat_pkg::outcome_t          outcome_next;
  logic                         do_remove;
  logic                         do_append;
  logic                         is_master;
  logic                         accept;

  cidat_pkg::cell_cmd_t         cmd;
  logic [cidat_pkg::UID_W-1:0]  ids [CAPACITY];

  assign accept    = start & ~busy;
  assign busy      = (state != S_IDLE);
  assign is_master = (uid == master_id);

  // ring of cells, each fed by its upper neighbor, the top one by cell 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cidat_cell #(
      .INDEX (i),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .neighbor_id (ids[(i + 1) % CAPACITY]),
      .id          (ids[i])
    );
  end

  // decision for the item once the search is done
  always_comb begin
    master_id_load    = 1'b0;
    master_valid_next = master_valid;
    program_mode_next = program_mode;
    count_next        = count;
    do_remove         = 1'b0;
    do_append         = 1'b0;
    outcome_next      = cidat_pkg::OC_DENIED;
    if (action) begin
      master_valid_next = 1'b0;
      program_mode_next = 1'b0;
      count_next        = '0;
      outcome_next      = cidat_pkg::OC_WIPED;
    end else if (!master_valid) begin
      master_id_load    = 1'b1;
      master_valid_next = 1'b1;
      outcome_next      = cidat_pkg::OC_MASTER_SET;
    end else if (!program_mode) begin
      if (is_master) begin
        program_mode_next = 1'b1;
        outcome_next      = cidat_pkg::OC_ENTER_PROG;
      end else if (found) begin
        outcome_next = cidat_pkg::OC_GRANTED;
      end else begin
        outcome_next = cidat_pkg::OC_DENIED;
      end
    end else if (is_master) begin
      program_mode_next = 1'b0;
      outcome_next      = cidat_pkg::OC_EXIT_PROG;
    end else if (found) begin
      do_remove    = 1'b1;
      count_next   = CNT_W'(count - 1'b1);
      outcome_next = cidat_pkg::OC_REMOVED;
    end else if (count == CNT_W'(CAPACITY)) begin
      outcome_next = cidat_pkg::OC_FULL;
    end else begin
      do_append    = 1'b1;
      count_next   = CNT_W'(count + 1'b1);
      outcome_next = cidat_pkg::OC_ADDED;
    end
  end

  // command broadcast to the cells
  always_comb begin
    cmd        = '0;
    cmd.rotate = (state == S_SEARCH);
    cmd.remove = (state == S_FINISH) & do_remove;
    cmd.append = (state == S_FINISH) & do_append;
    cmd.slot   = cidat_pkg::SLOT_MAX_W'(slot);
    cmd.count  = cidat_pkg::CNT_MAX_W'(count);
    cmd.uid    = uid;
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      master_valid <= 1'b0;
      program_mode <= 1'b0;
      count        <= '0;
      done         <= 1'b0;
      found        <= 1'b0;
      step         <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            found <= 1'b0;
            step  <= '0;
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          // cell 0 holds entry number step on this rotation
          if (!found && (CNT_W'(step) < count) && (ids[0] == uid)) begin
            found <= 1'b1;
          end
          if (step == IDX_W'(CAPACITY - 1)) begin
            state <= S_FINISH;
          end else begin
            step <= IDX_W'(step + 1'b1);
          end
        end
        S_FINISH: begin
          master_valid <= master_valid_next;
          program_mode <= program_mode_next;
          count        <= count_next;
          done         <= 1'b1;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      action <= item.action;
      uid    <= item.card_uid;
    end
    if (state == S_SEARCH && !found && (CNT_W'(step) < count) && (ids[0] == uid)) begin
      slot <= step;
    end
    if (state == S_FINISH) begin
      if (master_id_load) begin
        master_id <= uid;
      end
      result.outcome         <= outcome_next;
      result.record_count    <= cidat_pkg::COUNT_W'(count_next);
      result.in_program_mode <= program_mode_next;
    end
  end

  // checks
  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_FINISH))
    else $error("result beat without a finished item");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_prog_needs_master: assert property (@(posedge clk) disable iff (rst)
    program_mode |-> master_valid)
    else $error("program mode without a master");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted beat did not raise busy");

endmodule

// ===== hdl/cidat_cell.sv =====
// cidat_cell: one table entry in the ring of card id cells
// depends on cidat_pkg (cell_cmd_t, UID_W)
`timescale 1ns / 1ps

module cidat_cell #(
  parameter int INDEX = 0,
  parameter int IDX_W = 5,
  parameter int CNT_W = 6
) (
  input  logic                    clk,
  input  cidat_pkg::cell_cmd_t    cmd,
  input  logic [cidat_pkg::UID_W-1:0] neighbor_id,
  output logic [cidat_pkg::UID_W-1:0] id
);

  logic shift_en;
  logic load_en;

  // take the neighbor on a rotation step, or on removal at or above the slot
  assign shift_en = cmd.rotate |
                    (cmd.remove & (IDX_W'(INDEX) >= cmd.slot[IDX_W-1:0]));
  // append lands in the cell just past the last entry
  assign load_en  = cmd.append & (CNT_W'(INDEX) == cmd.count[CNT_W-1:0]);

  // entry storage
  always_ff @(posedge clk) begin
    if (load_en) begin
      id <= cmd.uid;
    end else if (shift_en) begin
      id <= neighbor_id;
    end
  end

endmodule

// ===== test/card_id_access_table_core_test.sv =====
// card_id_access_table_core_test: self-checking bench for the card id access table
// drives directed and random card beats, predicts each result and checks it
// depends on cidat_pkg and card_id_access_table_core
`timescale 1ns / 1ps

module card_id_access_table_core_test;
  import cidat_pkg::*;

  localparam int CAPACITY = CAPACITY_DEF;
  localparam bit ACT_SCAN = 1'b0;
  localparam bit ACT_WIPE = 1'b1;
  localparam int LAST_ITEM = 1375;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  in_t  item = '0;
  logic busy;
  logic done;
  out_t result;

  // typed expectation that travels with the current beat
  bit   beat_typed = 1'b0;
  out_t beat_exp = '0;

  // predicted table state
  logic [UID_W-1:0] tbl_master_id = '0;
  bit               tbl_master_set = 1'b0;
  bit               tbl_prog_mode = 1'b0;
  int               tbl_count = 0;
  logic [UID_W-1:0] tbl_ids [CAPACITY];

  out_t pending_outcomes [$];
  int   mismatch_count = 0;
  int   items_sent = 0;
  int   sender_idle_pct = 17;

  // directed beats; typed rows carry their result, the rest use the predictor
  typedef struct packed {
    bit               action;
    logic [UID_W-1:0] uid;
    bit               typed;
    out_t             want;
  } row_t;

  row_t directed_rows [25] = '{
    '{ACT_WIPE, 32'h0000_0000, 1'b1, '{OC_WIPED,      6'd0, 1'b0}},
    '{ACT_SCAN, 32'hFFFF_FFFF, 1'b1, '{OC_MASTER_SET, 6'd0, 1'b0}},
    '{ACT_SCAN, 32'h0000_0000, 1'b1, '{OC_DENIED,     6'd0, 1'b0}},
    '{ACT_SCAN, 32'hFFFF_FFFF, 1'b1, '{OC_ENTER_PROG, 6'd0, 1'b1}},
    '{ACT_SCAN, 32'hFFFF_FFFF, 1'b1, '{OC_EXIT_PROG,  6'd0, 1'b0}},
    '{ACT_SCAN, 32'hFFFF_FFFF, 1'b1, '{OC_ENTER_PROG, 6'd0, 1'b1}},
    '{ACT_SCAN, 32'h0000_0000, 1'b1, '{OC_ADDED,      6'd1, 1'b1}},
    '{ACT_SCAN, 32'h8000_0000, 1'b1, '{OC_ADDED,      6'd2, 1'b1}},
    '{ACT_SCAN, 32'h0000_0001, 1'b1, '{OC_ADDED,      6'd3, 1'b1}},
    '{ACT_SCAN, 32'h7FFF_FFFE, 1'b1, '{OC_ADDED,      6'd4, 1'b1}},
    '{ACT_SCAN, 32'h8000_0000, 1'b1, '{OC_REMOVED,    6'd3, 1'b1}},
    '{ACT_SCAN, 32'h7FFF_FFFE, 1'b1, '{OC_REMOVED,    6'd2, 1'b1}},
    '{ACT_SCAN, 32'h0000_0000, 1'b1, '{OC_REMOVED,    6'd1, 1'b1}},
    '{ACT_SCAN, 32'h0000_0000, 1'b1, '{OC_ADDED,      6'd2, 1'b1}},
    '{ACT_SCAN, 32'hFFFF_FFFF, 1'b1, '{OC_EXIT_PROG,  6'd2, 1'b0}},
    '{ACT_SCAN, 32'h0000_0001, 1'b0, '0},
    '{ACT_SCAN, 32'h0000_0000, 1'b0, '0},
    '{ACT_SCAN, 32'h8000_0000, 1'b0, '0},
    '{ACT_SCAN, 32'hFFFF_FFFE, 1'b0, '0},
    '{ACT_WIPE, 32'hFFFF_FFFF, 1'b1, '{OC_WIPED,      6'd0, 1'b0}},
    '{ACT_SCAN, 32'h0000_0001, 1'b1, '{OC_MASTER_SET, 6'd0, 1'b0}},
    '{ACT_WIPE, 32'h0000_0000, 1'b1, '{OC_WIPED,      6'd0, 1'b0}},
    '{ACT_SCAN, 32'h0000_0000, 1'b1, '{OC_MASTER_SET, 6'd0, 1'b0}},
    '{ACT_SCAN, 32'h0000_0000, 1'b1, '{OC_ENTER_PROG, 6'd0, 1'b1}},
    '{ACT_SCAN, 32'h0000_0000, 1'b1, '{OC_EXIT_PROG,  6'd0, 1'b0}}
  };

  card_id_access_table_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // slot of a listed id, or the count when it is not listed
  function automatic int slot_of(logic [UID_W-1:0] uid);
    int slot;
    slot = tbl_count;
    for (int i = 0; i < tbl_count; i++)
      if (slot == tbl_count && tbl_ids[i] == uid) slot = i;
    return slot;
  endfunction

  // access decision for one beat; updates the predicted table
  function automatic out_t access_decision(in_t beat);
    out_t r;
    int   slot;
    slot = slot_of(beat.card_uid);
    if (beat.action == ACT_WIPE) begin
      tbl_master_id  = '0;
      tbl_master_set = 1'b0;
      tbl_prog_mode  = 1'b0;
      tbl_count      = 0;
      r.outcome      = OC_WIPED;
    end else if (!tbl_master_set) begin
      tbl_master_id  = beat.card_uid;
      tbl_master_set = 1'b1;
      r.outcome      = OC_MASTER_SET;
    end else if (!tbl_prog_mode) begin
      if (beat.card_uid == tbl_master_id) begin
        tbl_prog_mode = 1'b1;
        r.outcome     = OC_ENTER_PROG;
      end else if (slot < tbl_count) begin
        r.outcome = OC_GRANTED;
      end else begin
        r.outcome = OC_DENIED;
      end
    end else if (beat.card_uid == tbl_master_id) begin
      tbl_prog_mode = 1'b0;
      r.outcome     = OC_EXIT_PROG;
    end else if (slot < tbl_count) begin
      // later entries move down one place
      for (int i = slot; i + 1 < tbl_count; i++) tbl_ids[i] = tbl_ids[i + 1];
      tbl_count--;
      r.outcome = OC_REMOVED;
    end else if (tbl_count >= CAPACITY) begin
      r.outcome = OC_FULL;
    end else begin
      tbl_ids[tbl_count] = beat.card_uid;
      tbl_count++;
      r.outcome = OC_ADDED;
    end
    r.record_count    = tbl_count[COUNT_W-1:0];
    r.in_program_mode = tbl_prog_mode;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 40) $display("%0t ns: %s", $time, what);
  endtask

  // result check and prediction at each rising edge
  always @(posedge clk) begin : watch_beats
    out_t want;
    if (!rst) begin
      if (done) begin
        if (pending_outcomes.size() == 0) begin
          report_mismatch("result beat with nothing pending");
        end else begin
          want = pending_outcomes.pop_front();
          if (result.outcome !== want.outcome)
            report_mismatch($sformatf("outcome %0d, want %0d",
                                      result.outcome, want.outcome));
          if (result.record_count !== want.record_count)
            report_mismatch($sformatf("record_count %0d, want %0d",
                                      result.record_count, want.record_count));
          if (result.in_program_mode !== want.in_program_mode)
            report_mismatch($sformatf("in_program_mode %0b, want %0b",
                                      result.in_program_mode, want.in_program_mode));
        end
      end
      if (start && !busy) begin
        want = access_decision(item);
        if (beat_typed) want = beat_exp;
        pending_outcomes.push_back(want);
      end
    end
  end

  // present one beat from a falling edge, return at the falling edge after accept
  task automatic send_beat(bit act, logic [UID_W-1:0] uid, bit typed, out_t want);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 40)) @(negedge clk);
    end
    start      <= 1'b1;
    item       <= '{act, uid};
    beat_typed <= typed;
    beat_exp   <= want;
    do @(posedge clk); while (busy);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_card(logic [UID_W-1:0] uid);
    send_beat(ACT_SCAN, uid, 1'b0, '0);
  endtask

  // hold off until every result is in, then let the block settle
  task automatic settle_idle();
    start <= 1'b0;
    wait (pending_outcomes.size() == 0);
    repeat (CAPACITY + 8) @(negedge clk);
  endtask

  // listed ids, corner values, the master or fresh random ids
  function automatic logic [UID_W-1:0] pick_uid(bit with_master);
    int r;
    r = $urandom_range(99);
    if (r < 45 && tbl_count > 0) return tbl_ids[$urandom_range(0, tbl_count - 1)];
    if (r < 55) begin
      case ($urandom_range(4))
        0: return 32'h0000_0000;
        1: return 32'hFFFF_FFFF;
        2: return 32'h8000_0000;
        3: return 32'h0000_0001;
        default: return 32'h7FFF_FFFF;
      endcase
    end
    if (r < 62 && with_master) return tbl_master_id;
    return $urandom;
  endfunction

  // program the table up to capacity, overflow it, remove a few, leave
  task automatic fill_table();
    logic [UID_W-1:0] uid;
    if (!tbl_master_set) send_card($urandom);
    if (!tbl_prog_mode) send_card(tbl_master_id);
    while (tbl_count < CAPACITY) begin
      uid = $urandom;
      if (uid != tbl_master_id && slot_of(uid) == tbl_count) send_card(uid);
    end
    repeat ($urandom_range(1, 3)) begin
      uid = $urandom;
      if (uid != tbl_master_id) send_card(uid);
    end
    repeat ($urandom_range(0, 3))
      if (tbl_count > 0) send_card(tbl_ids[$urandom_range(0, tbl_count - 1)]);
    send_card(tbl_master_id);
  endtask

  // one random session: mostly well formed, some noise
  task automatic run_session();
    int kind;
    kind = $urandom_range(99);
    if (!tbl_master_set) begin
      send_card(pick_uid(1'b0));
    end else if (kind < 3) begin
      send_beat(ACT_WIPE, $urandom, 1'b0, '0);
    end else if (kind < 10) begin
      fill_table();
    end else if (kind < 55) begin
      // edit session in program mode
      if (!tbl_prog_mode) send_card(tbl_master_id);
      repeat ($urandom_range(1, 8)) send_card(pick_uid(1'b0));
      if (tbl_prog_mode) send_card(tbl_master_id);
    end else if (kind < 90) begin
      // access scans in normal mode
      if (tbl_prog_mode) send_card(tbl_master_id);
      repeat ($urandom_range(1, 6)) send_card(pick_uid(1'b1));
    end else begin
      repeat ($urandom_range(1, 4))
        send_beat(($urandom_range(15) == 0) ? ACT_WIPE : ACT_SCAN, pick_uid(1'b1),
                  1'b0, '0);
    end
  endtask

  // reset, directed table, then three random phases
  initial begin : stimulus
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (directed_rows[i])
      send_beat(directed_rows[i].action, directed_rows[i].uid, directed_rows[i].typed,
                directed_rows[i].want);
    settle_idle();
    fill_table();
    while (items_sent < LAST_ITEM / 3) run_session();
    settle_idle();
    sender_idle_pct = 64;
    while (items_sent < 2 * LAST_ITEM / 3) run_session();
    settle_idle();
    sender_idle_pct = 0;
    while (items_sent < LAST_ITEM) run_session();
    settle_idle();
    if (mismatch_count == 0) begin
      $display("card_id_access_table_core: match");
    end else begin
      $display("card_id_access_table_core: mismatch");
    end
    $finish;
  end

  // run limit
  initial begin : run_limit
    #6_000_000;
    $display("card_id_access_table_core: mismatch");
    $finish;
  end

endmodule
